/* rtl/losg_pkg.sv */
// Shared types and constants for the lidar obstacle speed governor.
// Holds the beat payload structs, opcode and register index codes, and the window test.
// No dependencies.
package losg_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE       = 2'd0,
    OP_TICK         = 2'd1,
    OP_FORCE_STOP   = 2'd2,
    OP_FORCE_RESUME = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_AHEAD_INDEX       = 3'd0,
    REG_NORMAL_HALF_WIDTH = 3'd1,
    REG_FORCED_HALF_WIDTH = 3'd2,
    REG_SLOW_DISTANCE     = 3'd3,
    REG_STOP_DISTANCE     = 3'd4,
    REG_NORMAL_SLOW_SPEED = 3'd5,
    REG_FORCED_SLOW_SPEED = 3'd6,
    REG_CLEAR_TICKS       = 3'd7
  } reg_idx_t;

  localparam logic [11:0] SLOW_TURN_RATE = 12'd1000;
  localparam logic [11:0] FULL_SPEED     = 12'd1000;
  localparam logic [11:0] FULL_TURN_RATE = 12'd2000;
  localparam logic [15:0] NO_READING     = 16'hFFFF;
  localparam logic [31:0] TIMER_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    op_t         operation;
    logic [11:0] sample_index;
    logic [15:0] range_mm;
    logic        range_finite;
    logic        scan_last;
  } in_t;

  typedef struct packed {
    logic        speed_write;
    logic [11:0] speed_limit;
    logic        turn_write;
    logic [11:0] turn_limit;
  } out_t;

  typedef struct packed {
    logic [11:0] ahead_index;
    logic [11:0] normal_half_width;
    logic [11:0] forced_half_width;
    logic [15:0] slow_distance;
    logic [15:0] stop_distance;
    logic [11:0] normal_slow_speed;
    logic [11:0] forced_slow_speed;
    logic [31:0] clear_ticks;
  } cfg_t;

  typedef struct packed {
    logic        scan_end;
    logic [15:0] normal_min;
    logic [15:0] forced_min;
  } scan_t;

  function automatic logic in_window(logic [11:0] idx, logic [11:0] center,
                                     logic [11:0] half);
    logic [12:0] idx_plus;
    logic [12:0] upper;
    idx_plus = {1'b0, idx} + {1'b0, half};
    upper    = {1'b0, center} + {1'b0, half};
    return (idx_plus >= {1'b0, center}) && ({1'b0, idx} <= upper);
  endfunction

endpackage

/* rtl/losg_cfg.sv */
// Configuration register file of the lidar obstacle speed governor.
// Depends on losg_pkg for the register index codes and the cfg_t struct.
module losg_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  losg_pkg::reg_idx_t cfg_index,
  input  logic [31:0]       cfg_data,
  output losg_pkg::cfg_t    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ahead_index       <= 12'd0;
      cfg.normal_half_width <= 12'd4;
      cfg.forced_half_width <= 12'd4;
      cfg.slow_distance     <= 16'd8000;
      cfg.stop_distance     <= 16'd5000;
      cfg.normal_slow_speed <= 12'd500;
      cfg.forced_slow_speed <= 12'd700;
      cfg.clear_ticks       <= 32'd7000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        losg_pkg::REG_AHEAD_INDEX:       cfg.ahead_index       <= cfg_data[11:0];
        losg_pkg::REG_NORMAL_HALF_WIDTH: cfg.normal_half_width <= cfg_data[11:0];
        losg_pkg::REG_FORCED_HALF_WIDTH: cfg.forced_half_width <= cfg_data[11:0];
        losg_pkg::REG_SLOW_DISTANCE:     cfg.slow_distance     <= cfg_data[15:0];
        losg_pkg::REG_STOP_DISTANCE:     cfg.stop_distance     <= cfg_data[15:0];
        losg_pkg::REG_NORMAL_SLOW_SPEED: cfg.normal_slow_speed <= cfg_data[11:0];
        losg_pkg::REG_FORCED_SLOW_SPEED: cfg.forced_slow_speed <= cfg_data[11:0];
        losg_pkg::REG_CLEAR_TICKS:       cfg.clear_ticks       <= cfg_data;
      endcase
    end
  end

endmodule

/* rtl/losg_scan.sv */
// Window compare and running per-scan minima for the normal and forced windows.
// Depends on losg_pkg for in_t, cfg_t, scan_t and the window test.
module losg_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  losg_pkg::in_t   item,
  input  losg_pkg::cfg_t  cfg,
  output losg_pkg::scan_t scan
);

  logic [15:0] normal_min;
  logic [15:0] forced_min;
  logic [15:0] normal_min_next;
  logic [15:0] forced_min_next;
  logic        is_sample;
  logic        hit_normal;
  logic        hit_forced;

  assign is_sample  = (item.operation == losg_pkg::OP_SAMPLE);
  assign hit_normal = is_sample && item.range_finite &&
                      losg_pkg::in_window(item.sample_index, cfg.ahead_index,
                                          cfg.normal_half_width);
  assign hit_forced = is_sample && item.range_finite &&
                      losg_pkg::in_window(item.sample_index, cfg.ahead_index,
                                          cfg.forced_half_width);

  always_comb begin
    normal_min_next = (hit_normal && (item.range_mm < normal_min)) ? item.range_mm : normal_min;
    forced_min_next = (hit_forced && (item.range_mm < forced_min)) ? item.range_mm : forced_min;
    scan.scan_end   = is_sample && item.scan_last;
    scan.normal_min = normal_min_next;
    scan.forced_min = forced_min_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_min <= losg_pkg::NO_READING;
      forced_min <= losg_pkg::NO_READING;
    end else if (step && is_sample) begin
      if (item.scan_last) begin
        normal_min <= losg_pkg::NO_READING;
        forced_min <= losg_pkg::NO_READING;
      end else begin
        normal_min <= normal_min_next;
        forced_min <= forced_min_next;
      end
    end
  end

endmodule

/* rtl/losg_gov.sv */
// Mode, clear timer and speed decision logic with the result register.
// Depends on losg_pkg for opcodes, limits and the scan_t, cfg_t and out_t structs.
module losg_gov (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  losg_pkg::op_t   operation,
  input  losg_pkg::scan_t scan,
  input  losg_pkg::cfg_t  cfg,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_stall,
  output losg_pkg::out_t  out_data
);

  logic        forced_mode;
  logic        obstacle_seen;
  logic [31:0] clear_timer;
  logic [11:0] last_speed;
  logic        last_speed_known;

  logic        forced_mode_next;
  logic        obstacle_seen_next;
  logic [31:0] clear_timer_next;
  logic [11:0] last_speed_next;
  logic        last_speed_known_next;

  logic        spd_req;
  logic [11:0] spd_val;
  logic        trn_req;
  logic [11:0] trn_val;
  logic        spd_write;
  logic        res_valid;
  losg_pkg::out_t res;

  assign advance = !out_valid || !out_stall;

  always_comb begin
    forced_mode_next   = forced_mode;
    obstacle_seen_next = obstacle_seen;
    clear_timer_next   = clear_timer;
    spd_req            = 1'b0;
    spd_val            = 12'd0;
    trn_req            = 1'b0;
    trn_val            = 12'd0;
    unique case (operation)
      losg_pkg::OP_SAMPLE: begin
        if (scan.scan_end) begin
          if (forced_mode) begin
            spd_req = 1'b1;
            trn_req = 1'b1;
            if (scan.forced_min < cfg.stop_distance) begin
              spd_val = 12'd0;
              trn_val = 12'd0;
            end else begin
              spd_val = cfg.forced_slow_speed;
              trn_val = losg_pkg::SLOW_TURN_RATE;
            end
          end else if (scan.normal_min < cfg.slow_distance) begin
            if (!obstacle_seen) begin
              clear_timer_next   = 32'd0;
              obstacle_seen_next = 1'b1;
              spd_req            = 1'b1;
              spd_val            = cfg.normal_slow_speed;
            end
          end else if (obstacle_seen) begin
            clear_timer_next   = 32'd0;
            obstacle_seen_next = 1'b0;
          end else if (clear_timer > cfg.clear_ticks) begin
            spd_req = 1'b1;
            spd_val = losg_pkg::FULL_SPEED;
            trn_req = 1'b1;
            trn_val = losg_pkg::FULL_TURN_RATE;
          end
        end
      end
      losg_pkg::OP_TICK: begin
        if (clear_timer != losg_pkg::TIMER_MAX) begin
          clear_timer_next = clear_timer + 32'd1;
        end
      end
      losg_pkg::OP_FORCE_STOP: begin
        forced_mode_next = 1'b1;
        spd_req          = 1'b1;
        spd_val          = 12'd0;
      end
      losg_pkg::OP_FORCE_RESUME: begin
        forced_mode_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    spd_write             = spd_req && (!last_speed_known || (last_speed != spd_val));
    last_speed_next       = spd_write ? spd_val : last_speed;
    last_speed_known_next = last_speed_known || spd_write;
    res_valid             = spd_write || trn_req;
    res.speed_write       = spd_write;
    res.speed_limit       = spd_write ? spd_val : last_speed;
    res.turn_write        = trn_req;
    res.turn_limit        = trn_req ? trn_val : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forced_mode      <= 1'b0;
      obstacle_seen    <= 1'b0;
      clear_timer      <= losg_pkg::TIMER_MAX;
      last_speed       <= 12'd0;
      last_speed_known <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (step) begin
        forced_mode      <= forced_mode_next;
        obstacle_seen    <= obstacle_seen_next;
        clear_timer      <= clear_timer_next;
        last_speed       <= last_speed_next;
        last_speed_known <= last_speed_known_next;
      end
      if (advance) begin
        out_valid <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step) begin
      out_data <= res;
    end
  end

endmodule

/* rtl/lidar_obstacle_speed_governor_top.sv */
// Lidar obstacle speed governor: accepts one beat per cycle and issues a speed and
// turn limit result at most once per beat, through the input register and then the
// result register; throughput is one beat per cycle and only a stalled result
// register holds the input side. Depends on losg_pkg, losg_cfg, losg_scan and
// losg_gov.
module lidar_obstacle_speed_governor_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  losg_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output losg_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  losg_pkg::reg_idx_t cfg_index,
  input  logic [31:0]        cfg_data
);

  logic            in_q_valid;
  losg_pkg::in_t   in_q;
  logic            advance;
  logic            step;
  logic            accept;
  losg_pkg::cfg_t  cfg;
  losg_pkg::scan_t scan;

  assign in_stall = in_q_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign step     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  losg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  losg_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .cfg  (cfg),
    .scan (scan)
  );

  losg_gov u_gov (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .operation (in_q.operation),
    .scan      (scan),
    .cfg       (cfg),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/tb.sv */
// Testbench for lidar_obstacle_speed_governor_top: sends sample, tick and force beats
// and checks every speed/turn limit result against an in-bench governor predictor.
// Depends on losg_pkg and the governor RTL.
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN = 8;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  losg_pkg::in_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  losg_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  losg_pkg::reg_idx_t cfg_index;
  logic [31:0] cfg_data;

  losg_pkg::cfg_t regs;
  logic forced;
  logic obstacle;
  logic spd_known;
  logic [31:0] clear_cnt;
  logic [15:0] near_min;
  logic [15:0] far_min;
  logic [11:0] last_spd;
  losg_pkg::out_t limit_q[$];
  losg_pkg::out_t want;
  int errors = 0;
  int beats = 0;
  int results = 0;
  int settings = 0;
  int restores = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;

  lidar_obstacle_speed_governor_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= stall_on && ($urandom_range(99) < 12);
  end

  function automatic bit beam_hit(logic [11:0] idx, logic [11:0] half);
    int i;
    int c;
    int h;
    i = idx;
    c = regs.ahead_index;
    h = half;
    return (i >= c - h) && (i <= c + h);
  endfunction

  function automatic bit take_speed(logic [11:0] v);
    if (spd_known && last_spd == v) return 1'b0;
    last_spd = v;
    spd_known = 1'b1;
    return 1'b1;
  endfunction

  function automatic void gov_reset();
    regs.ahead_index = 12'd0;
    regs.normal_half_width = 12'd4;
    regs.forced_half_width = 12'd4;
    regs.slow_distance = 16'd8000;
    regs.stop_distance = 16'd5000;
    regs.normal_slow_speed = 12'd500;
    regs.forced_slow_speed = 12'd700;
    regs.clear_ticks = 32'd7000;
    forced = 1'b0;
    obstacle = 1'b0;
    spd_known = 1'b0;
    clear_cnt = losg_pkg::TIMER_MAX;
    near_min = losg_pkg::NO_READING;
    far_min = losg_pkg::NO_READING;
    last_spd = 12'd0;
  endfunction

  function automatic void govern_beat(losg_pkg::in_t b);
    losg_pkg::out_t r;
    r = '0;
    case (b.operation)
      losg_pkg::OP_SAMPLE: begin
        if (b.range_finite) begin
          if (beam_hit(b.sample_index, regs.normal_half_width) && b.range_mm < near_min)
            near_min = b.range_mm;
          if (beam_hit(b.sample_index, regs.forced_half_width) && b.range_mm < far_min)
            far_min = b.range_mm;
        end
        if (b.scan_last) begin
          if (forced) begin
            r.turn_write = 1'b1;
            if (far_min < regs.stop_distance) begin
              r.speed_write = take_speed(12'd0);
              r.turn_limit = 12'd0;
            end else begin
              r.speed_write = take_speed(regs.forced_slow_speed);
              r.turn_limit = losg_pkg::SLOW_TURN_RATE;
            end
          end else if (near_min < regs.slow_distance) begin
            if (!obstacle) begin
              clear_cnt = 32'd0;
              obstacle = 1'b1;
              r.speed_write = take_speed(regs.normal_slow_speed);
            end
          end else begin
            if (obstacle) begin
              clear_cnt = 32'd0;
              obstacle = 1'b0;
            end
            if (clear_cnt > regs.clear_ticks) begin
              r.speed_write = take_speed(losg_pkg::FULL_SPEED);
              r.turn_write = 1'b1;
              r.turn_limit = losg_pkg::FULL_TURN_RATE;
              restores++;
            end
          end
          near_min = losg_pkg::NO_READING;
          far_min = losg_pkg::NO_READING;
        end
      end
      losg_pkg::OP_TICK: begin
        if (clear_cnt != losg_pkg::TIMER_MAX) clear_cnt = clear_cnt + 32'd1;
      end
      losg_pkg::OP_FORCE_STOP: begin
        forced = 1'b1;
        r.speed_write = take_speed(12'd0);
      end
      default: begin
        forced = 1'b0;
      end
    endcase
    r.speed_limit = last_spd;
    if (r.speed_write || r.turn_write) limit_q = {limit_q, r};
  endfunction

  task automatic check_field(string name, logic [11:0] exp_v, logic [11:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (limit_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got %h", $time, out_data);
      end else begin
        want = limit_q.pop_front();
        check_field("speed_write", want.speed_write, out_data.speed_write);
        check_field("speed_limit", want.speed_limit, out_data.speed_limit);
        check_field("turn_write", want.turn_write, out_data.turn_write);
        check_field("turn_limit", want.turn_limit, out_data.turn_limit);
        results++;
      end
    end
  end

  task automatic send_beat(losg_pkg::in_t b);
    while (idle_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    govern_beat(b);
    beats++;
  endtask

  function automatic losg_pkg::in_t make_op(losg_pkg::op_t op);
    losg_pkg::in_t b;
    b.operation = op;
    b.sample_index = 12'($urandom);
    b.range_mm = 16'($urandom);
    b.range_finite = 1'($urandom);
    b.scan_last = 1'($urandom);
    return b;
  endfunction

  function automatic losg_pkg::in_t make_sample(logic [11:0] idx, logic [15:0] rng,
                                                logic fin, logic last);
    losg_pkg::in_t b;
    b.operation = losg_pkg::OP_SAMPLE;
    b.sample_index = idx;
    b.range_mm = rng;
    b.range_finite = fin;
    b.scan_last = last;
    return b;
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (limit_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(losg_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      losg_pkg::REG_AHEAD_INDEX:       regs.ahead_index = v[11:0];
      losg_pkg::REG_NORMAL_HALF_WIDTH: regs.normal_half_width = v[11:0];
      losg_pkg::REG_FORCED_HALF_WIDTH: regs.forced_half_width = v[11:0];
      losg_pkg::REG_SLOW_DISTANCE:     regs.slow_distance = v[15:0];
      losg_pkg::REG_STOP_DISTANCE:     regs.stop_distance = v[15:0];
      losg_pkg::REG_NORMAL_SLOW_SPEED: regs.normal_slow_speed = v[11:0];
      losg_pkg::REG_FORCED_SLOW_SPEED: regs.forced_slow_speed = v[11:0];
      default:                         regs.clear_ticks = v;
    endcase
  endtask

  task automatic load_settings(losg_pkg::cfg_t c);
    settle();
    write_reg(losg_pkg::REG_AHEAD_INDEX, 32'(c.ahead_index));
    write_reg(losg_pkg::REG_NORMAL_HALF_WIDTH, 32'(c.normal_half_width));
    write_reg(losg_pkg::REG_FORCED_HALF_WIDTH, 32'(c.forced_half_width));
    write_reg(losg_pkg::REG_SLOW_DISTANCE, 32'(c.slow_distance));
    write_reg(losg_pkg::REG_STOP_DISTANCE, 32'(c.stop_distance));
    write_reg(losg_pkg::REG_NORMAL_SLOW_SPEED, 32'(c.normal_slow_speed));
    write_reg(losg_pkg::REG_FORCED_SLOW_SPEED, 32'(c.forced_slow_speed));
    write_reg(losg_pkg::REG_CLEAR_TICKS, c.clear_ticks);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [11:0] pick12();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return losg_pkg::FULL_SPEED;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_half();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom_range(8));
    endcase
  endfunction

  function automatic losg_pkg::cfg_t random_settings();
    losg_pkg::cfg_t c;
    case ($urandom_range(4))
      0: c.ahead_index = 12'd0;
      1: c.ahead_index = 12'hFFF;
      default: c.ahead_index = 12'($urandom);
    endcase
    c.normal_half_width = pick_half();
    c.forced_half_width = pick_half();
    case ($urandom_range(9))
      0: c.slow_distance = 16'd0;
      1: c.slow_distance = 16'hFFFF;
      default: c.slow_distance = 16'($urandom_range(20000, 500));
    endcase
    c.stop_distance = 16'($urandom_range(c.slow_distance));
    c.normal_slow_speed = pick12();
    c.forced_slow_speed = pick12();
    case ($urandom_range(9))
      0: c.clear_ticks = 32'hFFFF_FFFF;
      1: c.clear_ticks = 32'd0;
      default: c.clear_ticks = 32'($urandom_range(40));
    endcase
    return c;
  endfunction

  task automatic send_scan(int len);
    int w;
    int idx;
    logic [15:0] rng;
    w = (regs.normal_half_width > regs.forced_half_width) ?
        regs.normal_half_width : regs.forced_half_width;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(7) == 0) begin
        idx = $urandom_range(4095);
      end else begin
        idx = int'(regs.ahead_index) + $urandom_range(2 * w + 4) - w - 2;
        if (idx < 0) idx = 0;
        if (idx > 4095) idx = 4095;
      end
      case ($urandom_range(5))
        0: rng = 16'($urandom_range(regs.stop_distance));
        1: rng = 16'($urandom_range(regs.slow_distance));
        2: rng = (regs.slow_distance > 16'hFF00) ? 16'hFFFF :
                 regs.slow_distance + 16'($urandom_range(200));
        3: rng = 16'hFFFF;
        4: rng = 16'd0;
        default: rng = 16'($urandom);
      endcase
      send_beat(make_sample(12'(idx), rng, $urandom_range(9) != 0, k == len - 1));
    end
  endtask

  task automatic mixed_traffic(int n);
    int stop_at;
    int pick;
    stop_at = beats + n;
    while (beats < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) send_scan($urandom_range(10, 1));
      else if (pick < 80) repeat ($urandom_range(12, 1)) send_beat(make_op(losg_pkg::OP_TICK));
      else if (pick < 85) send_beat(make_op(losg_pkg::OP_FORCE_STOP));
      else if (pick < 91) send_beat(make_op(losg_pkg::OP_FORCE_RESUME));
      else send_beat(make_op(losg_pkg::op_t'($urandom_range(3))));
    end
  endtask

  task automatic test_power_on();
    send_beat(make_sample(12'hFFF, 16'd0, 1'b1, 1'b1));
    send_beat(make_sample(12'd0, 16'd0, 1'b1, 1'b0));
    send_beat(make_op(losg_pkg::OP_TICK));
    send_beat(make_sample(12'd4, 16'hFFFF, 1'b0, 1'b1));
    send_beat(make_op(losg_pkg::OP_FORCE_STOP));
    send_beat(make_op(losg_pkg::OP_FORCE_STOP));
    send_beat(make_sample(12'd2, 16'd4999, 1'b1, 1'b1));
    send_beat(make_sample(12'd3, 16'd5000, 1'b1, 1'b1));
    send_beat(make_op(losg_pkg::OP_FORCE_RESUME));
    send_beat(make_sample(12'd0, 16'd9000, 1'b1, 1'b1));
  endtask

  task automatic test_register_extremes();
    losg_pkg::cfg_t c;
    c.ahead_index = 12'hFFF;
    c.normal_half_width = 12'd0;
    c.forced_half_width = 12'hFFF;
    c.slow_distance = 16'hFFFF;
    c.stop_distance = 16'd0;
    c.normal_slow_speed = 12'hFFF;
    c.forced_slow_speed = 12'd0;
    c.clear_ticks = 32'd0;
    load_settings(c);
    send_beat(make_sample(12'hFFF, 16'hFFFE, 1'b1, 1'b1));
    send_beat(make_sample(12'hFFE, 16'hFFFF, 1'b1, 1'b1));
    send_beat(make_op(losg_pkg::OP_TICK));
    send_beat(make_sample(12'd0, 16'd0, 1'b0, 1'b1));
    send_beat(make_op(losg_pkg::OP_FORCE_STOP));
    send_beat(make_sample(12'd0, 16'd0, 1'b1, 1'b1));
    send_beat(make_op(losg_pkg::OP_FORCE_RESUME));
    c.ahead_index = 12'd0;
    c.normal_half_width = 12'hFFF;
    c.slow_distance = 16'd0;
    c.clear_ticks = 32'hFFFF_FFFF;
    load_settings(c);
    send_beat(make_sample(12'hFFF, 16'd0, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 7; p++) begin
      load_settings(random_settings());
      mixed_traffic(170);
    end
  endtask

  task automatic test_no_idle();
    load_settings(random_settings());
    idle_on = 1'b0;
    stall_on = 1'b0;
    mixed_traffic(160);
    settle();
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = losg_pkg::REG_AHEAD_INDEX;
    cfg_data = 32'd0;
    gov_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_power_on();
    test_register_extremes();
    test_random_traffic();
    test_no_idle();
    settle();
    $display("Run covered %0d beats under %0d register settings plus reset values;",
             beats, settings);
    $display("%0d limit results checked, %0d of them full-speed restores.",
             results, restores);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
